[design/lruac_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lruac_pkg
// Shared constants and types for the age-counter LRU replacement block.
// ---------------------------------------------------------------------------
package lruac_pkg;

    localparam int LINES       = 256;
    localparam int AGE_WIDTH   = 16;
    localparam int IDX_WIDTH   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int ENTRY_WIDTH = AGE_WIDTH + 1;

    typedef logic [AGE_WIDTH-1:0]   age_t;
    typedef logic [IDX_WIDTH-1:0]   idx_t;
    // valid bit on top, age counter below
    typedef logic [ENTRY_WIDTH-1:0] entry_t;

    localparam age_t AGE_MAX = '1;

    localparam logic CMD_TOUCH   = 1'b0;
    localparam logic CMD_REPLACE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } lruac_state_t;

endpackage
`default_nettype wire

[design/lruac_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lruac_req_if
// Request channel: touch or replace command with a line index.
// ---------------------------------------------------------------------------
interface lruac_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] line;

    modport source (output valid, output command, output line, input ready);
    modport sink   (input valid, input command, input line, output ready);
endinterface
`default_nettype wire

[design/lruac_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lruac_rsp_if
// Response channel: chosen line and its prior empty flag.
// ---------------------------------------------------------------------------
interface lruac_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] chosen_line;
    logic       was_empty;

    modport source (output valid, output chosen_line, output was_empty, input ready);
    modport sink   (input valid, input chosen_line, input was_empty, output ready);
endinterface
`default_nettype wire

[design/lruac_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lruac_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lruac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                            wr_data,
    input  wire logic                                        rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[design/lru_age_counter_replacement.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lru_age_counter_replacement
// Age-counter LRU replacement over a fully associative set of lines.
// ---------------------------------------------------------------------------
// After reset the block clears its line RAM, one entry per cycle, and takes
// no request meanwhile. Each request then runs through the scan, last and
// finish states until the response is offered, and the next request can be
// taken once the block is back in idle. A request is served by one
// read-modify-write sweep through the line RAM, one entry per cycle: each
// entry holds a valid bit and an age, every valid line is aged (but on a
// touch of a line out of range) while the first empty line and the oldest
// line are tracked, then one final write clears the chosen line's age, on
// a touch only if the line is in range. The block takes no new request
// during a sweep; a finished response is held in an output register, so
// the next request is taken while it still waits, and that request's
// final write waits until the register is free.
// ---------------------------------------------------------------------------
module lru_age_counter_replacement (
    input  wire logic    clk,
    input  wire logic    rst_n,
    lruac_req_if.sink    req,
    lruac_rsp_if.source  rsp
);

    import lruac_pkg::*;

    lruac_state_t state_reg, state_next;
    idx_t         cnt_reg, cnt_next;
    logic         rd_pend_reg, rd_pend_next;
    idx_t         rd_idx_reg, rd_idx_next;
    logic         cmd_reg, cmd_next;
    logic [7:0]   line_reg, line_next;
    logic         found_reg, found_next;
    idx_t         first_inv_reg, first_inv_next;
    age_t         best_age_reg, best_age_next;
    idx_t         best_idx_reg, best_idx_next;
    logic         touch_valid_reg, touch_valid_next;
    logic         out_valid_reg, out_valid_next;
    logic [7:0]   out_line_reg, out_line_next;
    logic         out_empty_reg, out_empty_next;

    logic         ram_wr_en;
    idx_t         ram_wr_addr;
    entry_t       ram_wr_data;
    logic         ram_rd_en;
    idx_t         ram_rd_addr;
    entry_t       ram_rd_data;

    logic [IDX_WIDTH+7:0] line_ext;
    logic [IDX_WIDTH+7:0] chosen_ext;
    idx_t         line_idx;
    idx_t         chosen_idx;
    logic         line_in_range;
    logic         do_age;
    logic         pend_valid;
    age_t         rd_age;

    lruac_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (LINES)
    ) u_age_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign line_ext      = {{IDX_WIDTH{1'b0}}, line_reg};
    assign line_idx      = line_ext[IDX_WIDTH-1:0];
    assign line_in_range = (32'(line_reg) < 32'(LINES));
    assign do_age        = (cmd_reg == CMD_REPLACE) || line_in_range;
    assign chosen_idx    = found_reg ? first_inv_reg : best_idx_reg;
    assign chosen_ext    = {8'b0, chosen_idx};
    assign pend_valid    = ram_rd_data[AGE_WIDTH];
    assign rd_age        = ram_rd_data[AGE_WIDTH-1:0];

    assign rsp.valid       = out_valid_reg;
    assign rsp.chosen_line = out_line_reg;
    assign rsp.was_empty   = out_empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        cmd_reg         <= cmd_next;
        line_reg        <= line_next;
        first_inv_reg   <= first_inv_next;
        best_age_reg    <= best_age_next;
        best_idx_reg    <= best_idx_next;
        touch_valid_reg <= touch_valid_next;
        out_line_reg    <= out_line_next;
        out_empty_reg   <= out_empty_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        rd_pend_next     = 1'b0;
        rd_idx_next      = rd_idx_reg;
        cmd_next         = cmd_reg;
        line_next        = line_reg;
        found_next       = found_reg;
        first_inv_next   = first_inv_reg;
        best_age_next    = best_age_reg;
        best_idx_next    = best_idx_reg;
        touch_valid_next = touch_valid_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_line_next    = out_line_reg;
        out_empty_next   = out_empty_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = rd_idx_reg;
        ram_wr_data      = {1'b1, rd_age + age_t'(1)};
        ram_rd_en        = 1'b0;
        ram_rd_addr      = cnt_reg;
        req.ready        = 1'b0;

        // entry read last cycle: age it and track first empty and oldest line
        if (rd_pend_reg)
        begin
            if (pend_valid && do_age && (rd_age != AGE_MAX))
            begin
                ram_wr_en = 1'b1;
            end
            if (!pend_valid && !found_reg)
            begin
                found_next     = 1'b1;
                first_inv_next = rd_idx_reg;
            end
            if (pend_valid && (rd_age > best_age_reg))
            begin
                best_age_next = rd_age;
                best_idx_next = rd_idx_reg;
            end
            if (rd_idx_reg == line_idx)
            begin
                touch_valid_next = pend_valid;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cnt_reg;
                ram_wr_data = '0;
                if (cnt_reg == idx_t'(LINES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + idx_t'(1);
                end
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cmd_next      = req.command;
                    line_next     = req.line;
                    found_next    = 1'b0;
                    best_age_next = '0;
                    best_idx_next = '0;
                    cnt_next      = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ram_rd_en    = 1'b1;
                rd_pend_next = 1'b1;
                rd_idx_next  = cnt_reg;
                if (cnt_reg == idx_t'(LINES - 1))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + idx_t'(1);
                end
            end
            ST_LAST:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    if (cmd_reg == CMD_REPLACE)
                    begin
                        ram_wr_en      = 1'b1;
                        ram_wr_addr    = chosen_idx;
                        ram_wr_data    = {1'b1, {AGE_WIDTH{1'b0}}};
                        out_line_next  = chosen_ext[7:0];
                        out_empty_next = found_reg;
                    end
                    else
                    begin
                        // touched line keeps its valid bit
                        ram_wr_en      = line_in_range;
                        ram_wr_addr    = line_idx;
                        ram_wr_data    = {touch_valid_reg, {AGE_WIDTH{1'b0}}};
                        out_line_next  = line_reg;
                        out_empty_next = line_in_range && !touch_valid_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[tb/tb_lru_age_counter_replacement.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lru_age_counter_replacement
// Runs touch and replace requests through the age-counter LRU block with
// random bursts and stalls on both channels. A local copy of the valid bits
// and age counters predicts each chosen line and its empty flag.
// ---------------------------------------------------------------------------
module tb_lru_age_counter_replacement;
    import lruac_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_REQS     = 1800;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int SETTLE_CYCLES   = 300;
    localparam int IDLE_LIMIT      = 10000;

    typedef struct {
        logic       command;
        logic [7:0] line;
        bit         drain;
    } lru_req_t;

    typedef struct {
        logic [7:0] chosen_line;
        logic       was_empty;
    } lru_pick_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lruac_req_if req_if ();
    lruac_rsp_if rsp_if ();

    lru_age_counter_replacement DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // local copy of the replacement state
    age_t      line_age_copy   [LINES];
    bit        line_valid_copy [LINES];

    lru_req_t  pending_q [$];
    lru_pick_t expected_picks [$];
    lru_pick_t want_pick;

    int errors       = 0;
    int touches      = 0;
    int replaces     = 0;
    int evictions    = 0;
    int empty_hits   = 0;
    int responses    = 0;
    int oldest_age   = 0;
    int lines_filled = 0;
    int idle_cycles  = 0;

    int burst_left;
    int gap_left;
    int rsp_seen;
    int next_hold;
    int hold_left;
    int phase_left;
    int stall_mode;

    function automatic void age_valid_lines();
        int k;
        for (k = 0; k < LINES; k++)
        begin
            if (line_valid_copy[k] && line_age_copy[k] != AGE_MAX)
                line_age_copy[k] = line_age_copy[k] + 1'b1;
            if (line_valid_copy[k] && int'(line_age_copy[k]) > oldest_age)
                oldest_age = int'(line_age_copy[k]);
        end
    endfunction

    function automatic lru_pick_t update_lru(logic command, logic [7:0] line);
        lru_pick_t pick;
        int        victim;
        int        k;
        victim = -1;
        if (command == CMD_TOUCH)
        begin
            touches++;
            pick.chosen_line = line;
            pick.was_empty   = 1'b0;
            if (int'(line) < LINES)
            begin
                pick.was_empty = !line_valid_copy[line];
                age_valid_lines();
                line_age_copy[line] = '0;
            end
        end
        else
        begin
            replaces++;
            for (k = 0; k < LINES && victim < 0; k++)
                if (!line_valid_copy[k])
                    victim = k;
            if (victim < 0)
            begin
                // all lines valid: oldest wins, lowest index on a tie
                evictions++;
                victim = 0;
                for (k = 1; k < LINES; k++)
                    if (line_age_copy[k] > line_age_copy[victim])
                        victim = k;
            end
            pick.chosen_line = victim[7:0];
            pick.was_empty   = !line_valid_copy[victim];
            age_valid_lines();
            line_valid_copy[victim] = 1'b1;
            line_age_copy[victim]   = '0;
        end
        return pick;
    endfunction

    task automatic queue_request(logic command, logic [7:0] line, bit drain);
        lru_req_t r;
        r.command = command;
        r.line    = line;
        r.drain   = drain;
        pending_q.push_back(r);
        if (command == CMD_REPLACE && lines_filled < LINES)
            lines_filled++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid   <= 1'b0;
            req_if.command <= CMD_TOUCH;
            req_if.line    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                expected_picks.push_back(update_lru(req_if.command, req_if.line));
            if (!req_if.valid || req_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain && expected_picks.size() > 0))
                begin
                    req_if.valid   <= 1'b1;
                    req_if.command <= pending_q[0].command;
                    req_if.line    <= pending_q[0].line;
                    void'(pending_q.pop_front());
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
                    end
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // response backpressure, with two long hold-offs to fill the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_seen   = 0;
            next_hold  = 0;
            hold_left  = 0;
            phase_left = 0;
            stall_mode = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
                rsp_seen++;
            if (hold_left == 0 && ((next_hold == 0 && rsp_seen >= 150) ||
                                   (next_hold == 1 && rsp_seen >= 1100)))
            begin
                hold_left = HOLD_OFF_CYCLES;
                next_hold++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    phase_left = (stall_mode == 3) ? $urandom_range(20, 400)
                                                   : $urandom_range(50, 800);
                end
                phase_left--;
                case (stall_mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_if.ready <= ($urandom_range(0, 7) == 0);
                    default: rsp_if.ready <= 1'b0;
                endcase
            end
        end
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            responses++;
            if (expected_picks.size() == 0)
            begin
                $display("[%0t] unexpected response: chosen_line %0d was_empty %0b",
                         $time, rsp_if.chosen_line, rsp_if.was_empty);
                errors++;
            end
            else
            begin
                want_pick = expected_picks.pop_front();
                if (rsp_if.chosen_line !== want_pick.chosen_line)
                begin
                    $display("[%0t] chosen_line mismatch: expected %0d, got %0d",
                             $time, want_pick.chosen_line, rsp_if.chosen_line);
                    errors++;
                end
                if (rsp_if.was_empty !== want_pick.was_empty)
                begin
                    $display("[%0t] was_empty mismatch: expected %0b, got %0b",
                             $time, want_pick.was_empty, rsp_if.was_empty);
                    errors++;
                end
                if (want_pick.was_empty)
                    empty_hits++;
            end
        end
    end

    // hang detection
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("[%0t] timeout: no handshake for %0d cycles, %0d responses pending",
                             $time, IDLE_LIMIT, expected_picks.size());
                    $display("lru_age_counter_replacement test failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int       i;
        logic     command;
        logic [7:0] line;

        req_if.valid   = 1'b0;
        req_if.command = CMD_TOUCH;
        req_if.line    = '0;
        rsp_if.ready   = 1'b0;
        for (i = 0; i < LINES; i++)
        begin
            line_age_copy[i]   = '0;
            line_valid_copy[i] = 1'b0;
        end

        // directed: empty lines, ignored line field, valid and invalid touches
        queue_request(CMD_TOUCH,   8'hFF, 1'b0);
        queue_request(CMD_TOUCH,   8'h00, 1'b0);
        queue_request(CMD_REPLACE, 8'hFF, 1'b0);
        queue_request(CMD_REPLACE, 8'h00, 1'b0);
        queue_request(CMD_REPLACE, 8'hAA, 1'b0);
        queue_request(CMD_TOUCH,   8'h01, 1'b0);
        queue_request(CMD_TOUCH,   8'h55, 1'b0);
        queue_request(CMD_TOUCH,   8'h55, 1'b0);
        queue_request(CMD_REPLACE, 8'h55, 1'b0);
        queue_request(CMD_TOUCH,   8'h00, 1'b0);
        queue_request(CMD_TOUCH,   8'h02, 1'b0);
        queue_request(CMD_REPLACE, 8'h7F, 1'b0);
        queue_request(CMD_TOUCH,   8'hAA, 1'b0);
        queue_request(CMD_TOUCH,   8'h80, 1'b0);

        // random: fills the store, then evicts by age while touches reorder it
        for (i = 0; i < RANDOM_REQS; i++)
        begin
            if ($urandom_range(0, 99) < 45)
            begin
                command = CMD_REPLACE;
                line    = 8'($urandom_range(0, 255));
            end
            else
            begin
                command = CMD_TOUCH;
                if (lines_filled > 0 && $urandom_range(0, 3) != 0)
                    line = 8'($urandom_range(0, lines_filled - 1));
                else
                    line = 8'($urandom_range(0, 255));
            end
            queue_request(command, line, i == 0 || i == 700 || i == 1400);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() > 0 || req_if.valid)
            @(posedge clk);
        while (expected_picks.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_picks.size() != 0)
        begin
            $display("[%0t] %0d expected responses never arrived", $time, expected_picks.size());
            errors++;
        end

        $display("ran %0d touches and %0d replaces, %0d replaces evicted the oldest line",
                 touches, replaces, evictions);
        $display("%0d responses checked, %0d on empty lines, oldest age reached %0d",
                 responses, empty_hits, oldest_age);
        if (errors == 0)
            $display("lru_age_counter_replacement test passed");
        else
            $display("lru_age_counter_replacement test failed");
        $finish;
    end

endmodule
